// ----- rtl/core/bitmap_text_blitter_defines.svh -----
// Assertion helpers for the blitter modules; only bmtb_back includes this file.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef BITMAP_TEXT_BLITTER_DEFINES_SVH
`define BITMAP_TEXT_BLITTER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define BMTB_ASSERT_NOW(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define BMTB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bmtb_pkg.sv -----
package bmtb_pkg;

	localparam int POS_W = 12;
	localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;
	localparam int GIDX_W = 3;
	localparam int GLYPH_NUM_W = 7;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [GIDX_W-1:0] TOP_BIT = 3'd7;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_CURSOR = 2'd1,
		OP_DRAW   = 2'd2
	} opcode_t;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_DRAW = 1'b1
	} cmd_kind_t;

	// One queued command. For a load, data is the row pattern; for a draw, the ink.
	typedef struct packed {
		cmd_kind_t               kind;
		logic [GLYPH_NUM_W-1:0]  glyph;
		logic [GIDX_W-1:0]       row_index;
		logic [7:0]              data;
		logic [POS_W-1:0]        col;
		logic [POS_W-1:0]        row;
	} cmd_t;

endpackage

// ----- rtl/core/bmtb_front.sv -----
module bmtb_front #(
	parameter int GLYPH_ROWS  = 8,
	parameter int GLYPH_COLS  = 8,
	parameter int GLYPH_COUNT = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_valid,
	output logic                          s_ready,
	input  logic [1:0]                    opcode,
	input  logic [bmtb_pkg::POS_W-1:0]    start_x,
	input  logic [bmtb_pkg::POS_W-1:0]    start_y,
	input  logic [7:0]                    char_code,
	input  logic [7:0]                    ink_color,
	input  logic [bmtb_pkg::GIDX_W-1:0]   row_index,
	input  logic [7:0]                    row_bits,
	input  logic                          q_full,
	output logic                          q_push,
	output bmtb_pkg::cmd_t                q_cmd
);

	localparam logic [7:0] GLYPH_LIMIT = 8'(GLYPH_COUNT);
	localparam logic [3:0] ROW_STEP = 4'(GLYPH_ROWS);
	localparam logic [3:0] COL_STEP = 4'(GLYPH_COLS);

	logic [bmtb_pkg::POS_W-1:0] col_q;
	logic [bmtb_pkg::POS_W-1:0] row_q;
	logic [bmtb_pkg::POS_W-1:0] margin_q;
	logic accept;
	logic is_draw;
	logic is_newline;
	logic load_ok;
	logic draw_ok;

	function automatic logic [bmtb_pkg::POS_W-1:0] sat_add(
		input logic [bmtb_pkg::POS_W-1:0] a,
		input logic [3:0] b
	);
		logic [bmtb_pkg::POS_W:0] s;
		s = {1'b0, a} + {9'd0, b};
		return s[bmtb_pkg::POS_W] ? bmtb_pkg::POS_MAX : s[bmtb_pkg::POS_W-1:0];
	endfunction

	always_comb begin
		s_ready    = !q_full;
		accept     = s_valid && !q_full;
		is_draw    = (opcode == bmtb_pkg::OP_DRAW);
		is_newline = (char_code == bmtb_pkg::NEWLINE_CODE);
		load_ok    = (opcode == bmtb_pkg::OP_LOAD) && (char_code < GLYPH_LIMIT)
			&& ({1'b0, row_index} < ROW_STEP);
		draw_ok    = is_draw && !is_newline && (char_code < GLYPH_LIMIT);
		q_push     = accept && (load_ok || draw_ok);

		q_cmd.kind      = is_draw ? bmtb_pkg::CMD_DRAW : bmtb_pkg::CMD_LOAD;
		q_cmd.glyph     = char_code[bmtb_pkg::GLYPH_NUM_W-1:0];
		q_cmd.row_index = row_index;
		q_cmd.data      = is_draw ? ink_color : row_bits;
		q_cmd.col       = col_q;
		q_cmd.row       = row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			margin_q <= '0;
		end else if (accept) begin
			unique case (opcode)
				bmtb_pkg::OP_CURSOR: begin
					col_q    <= start_x;
					margin_q <= start_x;
					row_q    <= start_y;
				end
				bmtb_pkg::OP_DRAW: begin
					if (is_newline) begin
						row_q <= sat_add(row_q, ROW_STEP);
						col_q <= margin_q;
					end else begin
						col_q <= sat_add(col_q, COL_STEP);
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/bmtb_fifo.sv -----
module bmtb_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bmtb_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output bmtb_pkg::cmd_t pop_cmd,
	output logic           empty
);

	bmtb_pkg::cmd_t                 slot_q [bmtb_pkg::QDEPTH];
	logic [bmtb_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [bmtb_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [bmtb_pkg::QPTR_W:0]      count_q;
	logic                           do_push;
	logic                           do_pop;

	always_comb begin
		full    = (count_q == (bmtb_pkg::QPTR_W + 1)'(bmtb_pkg::QDEPTH));
		empty   = (count_q == '0);
		do_push = push && !full;
		do_pop  = pop && !empty;
		pop_cmd = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/bmtb_back.sv -----
`include "bitmap_text_blitter_defines.svh"

module bmtb_back #(
	parameter int SCREEN_W    = 320,
	parameter int SCREEN_H    = 200,
	parameter int GLYPH_ROWS  = 8,
	parameter int GLYPH_COLS  = 8,
	parameter int GLYPH_COUNT = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	output logic           q_pop,
	input  bmtb_pkg::cmd_t q_cmd,
	output logic           m_valid,
	input  logic           m_ready,
	output logic [15:0]    pixel_address,
	output logic [7:0]     pixel_color,
	output logic           last_pixel
);

	localparam int FONT_DEPTH = GLYPH_COUNT * 8;
	localparam int FONT_AW = $clog2(FONT_DEPTH);
	localparam int PY_W = bmtb_pkg::POS_W + 1;
	localparam logic [PY_W-1:0] W_LIMIT = PY_W'(SCREEN_W);
	localparam logic [PY_W-1:0] H_LIMIT = PY_W'(SCREEN_H);
	localparam logic [10:0] W_MUL = 11'(SCREEN_W);
	localparam logic [bmtb_pkg::GIDX_W-1:0] LAST_DX = bmtb_pkg::GIDX_W'(GLYPH_COLS - 1);
	localparam logic [bmtb_pkg::GIDX_W-1:0] LAST_DY = bmtb_pkg::GIDX_W'(GLYPH_ROWS - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t                              state_q;
	logic [7:0]                          font_mem [FONT_DEPTH];
	logic [7:0]                          font_rd_q;
	logic [bmtb_pkg::GLYPH_NUM_W-1:0]    glyph_q;
	logic [7:0]                          ink_q;
	logic [bmtb_pkg::POS_W-1:0]          col_q;
	logic [bmtb_pkg::POS_W-1:0]          row_q;
	logic [bmtb_pkg::GIDX_W-1:0]         dx_q;
	logic [bmtb_pkg::GIDX_W-1:0]         dy_q;
	logic [15:0]                         base_q;
	logic                                row_vis_q;
	logic                                pend_valid_q;
	logic [15:0]                         pend_addr_q;
	logic                                m_valid_q;
	logic [15:0]                         addr_out_q;
	logic [7:0]                          color_out_q;
	logic                                last_q;

	logic                                start_draw;
	logic                                mem_we;
	logic                                row_load;
	logic [bmtb_pkg::GLYPH_NUM_W-1:0]    glyph_sel;
	logic [bmtb_pkg::GIDX_W-1:0]         dy_sel;
	logic [bmtb_pkg::GLYPH_NUM_W+bmtb_pkg::GIDX_W-1:0] font_addr_full;
	logic [FONT_AW-1:0]                  font_addr;
	logic [PY_W-1:0]                     py_sel;
	logic [PY_W+10:0]                    base_prod;
	logic [PY_W-1:0]                     px;
	logic                                hit;
	logic                                out_free;
	logic                                stall;
	logic                                last_dx;
	logic                                last_dy;
	logic                                advance_row;
	logic                                out_load;
	logic [bmtb_pkg::GIDX_W-1:0]         dy_next;

	always_comb begin
		q_pop      = (state_q == ST_IDLE) && !q_empty;
		start_draw = q_pop && (q_cmd.kind == bmtb_pkg::CMD_DRAW);
		mem_we     = q_pop && (q_cmd.kind == bmtb_pkg::CMD_LOAD);

		dy_next = dy_q + 1'b1;
		last_dx = (dx_q == LAST_DX);
		last_dy = (dy_q == LAST_DY);

		px       = {1'b0, col_q} + {{(PY_W - bmtb_pkg::GIDX_W){1'b0}}, dx_q};
		hit      = (state_q == ST_SCAN) && row_vis_q
			&& font_rd_q[bmtb_pkg::TOP_BIT - dx_q] && (px < W_LIMIT);
		out_free = !m_valid_q || m_ready;
		stall    = hit && pend_valid_q && !out_free;

		advance_row = (state_q == ST_SCAN) && !stall && last_dx && !last_dy;
		row_load    = start_draw || advance_row;

		// The first row comes with the dequeued command; later rows are fetched
		// during the last column of the row before.
		if (start_draw) begin
			glyph_sel = q_cmd.glyph;
			dy_sel    = '0;
			py_sel    = {1'b0, q_cmd.row};
		end else begin
			glyph_sel = glyph_q;
			dy_sel    = dy_next;
			py_sel    = {1'b0, row_q} + {{(PY_W - bmtb_pkg::GIDX_W){1'b0}}, dy_next};
		end
		if (mem_we) begin
			font_addr_full = {q_cmd.glyph, q_cmd.row_index};
		end else begin
			font_addr_full = {glyph_sel, dy_sel};
		end
		font_addr = font_addr_full[FONT_AW-1:0];
		base_prod = py_sel * W_MUL;

		out_load = (hit && !stall && pend_valid_q)
			|| ((state_q == ST_FLUSH) && pend_valid_q && out_free);

		m_valid       = m_valid_q;
		pixel_address = addr_out_q;
		pixel_color   = color_out_q;
		last_pixel    = last_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			font_mem[font_addr] <= q_cmd.data;
		end
		if (row_load) begin
			font_rd_q <= font_mem[font_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (start_draw) begin
			glyph_q <= q_cmd.glyph;
			ink_q   <= q_cmd.data;
			col_q   <= q_cmd.col;
			row_q   <= q_cmd.row;
		end
		if (row_load) begin
			base_q    <= base_prod[15:0];
			row_vis_q <= (py_sel < H_LIMIT);
		end
		if (hit && !stall) begin
			pend_addr_q <= base_q + {{(16 - PY_W){1'b0}}, px};
		end
		if (out_load) begin
			addr_out_q  <= pend_addr_q;
			color_out_q <= ink_q;
			last_q      <= (state_q == ST_FLUSH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			dx_q         <= '0;
			dy_q         <= '0;
			pend_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start_draw) begin
						state_q <= ST_SCAN;
						dx_q    <= '0;
						dy_q    <= '0;
					end
				end
				ST_SCAN: begin
					if (!stall) begin
						if (hit) begin
							pend_valid_q <= 1'b1;
						end
						if (last_dx) begin
							dx_q <= '0;
							if (last_dy) begin
								dy_q    <= '0;
								state_q <= ST_FLUSH;
							end else begin
								dy_q <= dy_next;
							end
						end else begin
							dx_q <= dx_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BMTB_ASSERT_NOW(a_idle_no_pending, (state_q != ST_IDLE) || !pend_valid_q, "pixel held while idle")
	`BMTB_ASSERT_NEXT(a_flush_marks_last, (state_q == ST_FLUSH) && pend_valid_q && out_free, (state_q == ST_IDLE) && m_valid_q && last_q, "final pixel not marked last")
	`BMTB_ASSERT_NEXT(a_draw_starts_clean, start_draw, (state_q == ST_SCAN) && (dx_q == '0) && (dy_q == '0) && !pend_valid_q, "draw did not start at glyph origin")

endmodule

// ----- rtl/core/bitmap_text_blitter.sv -----
// Cursor commands and newlines are handled in the front end; font loads and draws are
// queued when accepted and leave the queue when the back end is idle.
// A draw then scans its glyph in the back end, one glyph bit a cycle while the output
// does not stall; a stalled output holds the scan. Each visible pixel is held back until
// the next one is found, and the last one is offered when the scan ends.
// Reset clears the cursor, margin, queue, sequencer and output valid; font rows are not cleared.
module bitmap_text_blitter #(
	parameter int SCREEN_W    = 320,
	parameter int SCREEN_H    = 200,
	parameter int GLYPH_ROWS  = 8,
	parameter int GLYPH_COLS  = 8,
	parameter int GLYPH_COUNT = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_x[11:0], start_y[23:12], char_code[31:24], ink_color[39:32],
	// row_index[42:40], row_bits[50:43], zero fill [55:51]
	input  logic [55:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_address[15:0], pixel_color[23:16]
	output logic [23:0] m_axis_tdata,
	// last_pixel: set on the final pixel transfer of a character
	output logic        m_axis_tlast
);

	// The front end tracks the cursor and margin itself, so cursor moves, newlines
	// and characters without a glyph never enter the queue. Only font row loads and
	// drawable characters are queued, carrying the cursor position that applies.
	bmtb_pkg::cmd_t push_cmd;
	bmtb_pkg::cmd_t pop_cmd;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	logic [15:0]    pixel_address;
	logic [7:0]     pixel_color;

	bmtb_front #(
		.GLYPH_ROWS  (GLYPH_ROWS),
		.GLYPH_COLS  (GLYPH_COLS),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_valid   (s_axis_tvalid),
		.s_ready   (s_axis_tready),
		.opcode    (s_axis_tuser),
		.start_x   (s_axis_tdata[11:0]),
		.start_y   (s_axis_tdata[23:12]),
		.char_code (s_axis_tdata[31:24]),
		.ink_color (s_axis_tdata[39:32]),
		.row_index (s_axis_tdata[42:40]),
		.row_bits  (s_axis_tdata[50:43]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	// A short command queue lets the host keep issuing commands while a glyph is
	// still being scanned out.
	bmtb_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// The back end owns the font memory. A load writes one row; a draw walks the
	// glyph row by row and bit by bit, holding each visible pixel back one step so
	// that the final transfer of the character can carry tlast.
	bmtb_back #(
		.SCREEN_W    (SCREEN_W),
		.SCREEN_H    (SCREEN_H),
		.GLYPH_ROWS  (GLYPH_ROWS),
		.GLYPH_COLS  (GLYPH_COLS),
		.GLYPH_COUNT (GLYPH_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_cmd         (pop_cmd),
		.m_valid       (m_axis_tvalid),
		.m_ready       (m_axis_tready),
		.pixel_address (pixel_address),
		.pixel_color   (pixel_color),
		.last_pixel    (m_axis_tlast)
	);

	assign m_axis_tdata = {pixel_color, pixel_address};

endmodule
